### rtl/core/jddc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddc_pkg
// Types and constants shared by the day number / calendar date converter.
// ----------------------------------------------------------------------------
package jddc_pkg;

  // request direction codes
  localparam logic REQ_DATE_TO_JDN = 1'b0;
  localparam logic REQ_JDN_TO_DATE = 1'b1;

  localparam logic [22:0] JD_OFFSET  = 23'd1721119;
  localparam logic [22:0] JD_MIN     = 23'd1721426;
  localparam logic [22:0] JD_MAX     = 23'd5373484;
  localparam logic [17:0] DAYS_400Y  = 18'd146097;
  localparam logic [10:0] DAYS_4Y    = 11'd1461;
  localparam logic [7:0]  DAYS_5MON  = 8'd153;

  localparam logic [3:0]  MONTH_MIN  = 4'd1;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [4:0]  DAY_MIN    = 5'd1;
  localparam logic [4:0]  DAY_MAX    = 5'd31;
  localparam logic [13:0] YEAR_MIN   = 14'd1;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;

  // number of register stages inside each conversion path
  localparam int unsigned PATH_STAGES = 8;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [13:0] year_in;
    logic [22:0] day_number_in;
  } req_t;

  typedef struct packed {
    logic [22:0] day_number_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [13:0] year_out;
    logic        range_error;
  } rsp_t;

  typedef struct packed {
    logic valid;
    rsp_t data;
  } beat_t;

endpackage

### rtl/core/jddc_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddc_encode
// Calendar date to Julian day number, eight register stages.
// ----------------------------------------------------------------------------
module jddc_encode (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  jddc_pkg::req_t req,
  output jddc_pkg::beat_t beat
);

  localparam int unsigned ALIGN = jddc_pkg::PATH_STAGES - 5;
  // ceil(2^26 / 100), exact for years below 18641
  localparam logic [19:0] RECIP_100 = 20'd671089;

  // days before the start of each month of a march-based year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] v;
    case (m)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // stage 1: range check and march-based month
  logic        err_c;
  logic [3:0]  m_c;
  logic [13:0] y_c;

  assign err_c = (req.month_in < jddc_pkg::MONTH_MIN) || (req.month_in > jddc_pkg::MONTH_MAX)
              || (req.day_in < jddc_pkg::DAY_MIN) || (req.day_in > jddc_pkg::DAY_MAX)
              || (req.year_in < jddc_pkg::YEAR_MIN) || (req.year_in > jddc_pkg::YEAR_MAX);
  assign m_c = (req.month_in > 4'd2) ? req.month_in - 4'd3 : req.month_in + 4'd9;
  assign y_c = (req.month_in > 4'd2) ? req.year_in : req.year_in - 14'd1;

  logic        s1_valid, s1_err;
  logic [3:0]  s1_m, s1_mon;
  logic [4:0]  s1_day;
  logic [13:0] s1_y, s1_yr;

  // stage 2: century by reciprocal
  logic [33:0] prod2;
  assign prod2 = 34'(s1_y) * 34'(RECIP_100);

  logic        s2_valid, s2_err;
  logic [3:0]  s2_m, s2_mon;
  logic [4:0]  s2_day;
  logic [13:0] s2_y, s2_yr;
  logic [6:0]  s2_c;

  // stage 3: year within century
  logic [13:0] ya_c;
  assign ya_c = s2_y - 14'(14'(s2_c) * 14'd100);

  logic        s3_valid, s3_err;
  logic [3:0]  s3_m, s3_mon;
  logic [4:0]  s3_day;
  logic [13:0] s3_yr;
  logic [6:0]  s3_c, s3_ya;

  // stage 4: the three partial terms
  logic [23:0] t1_full;
  logic [17:0] t2_full;
  logic [20:0] t3_c;
  assign t1_full = 24'(s3_c) * 24'(jddc_pkg::DAYS_400Y);
  assign t2_full = 18'(s3_ya) * 18'(jddc_pkg::DAYS_4Y);
  assign t3_c    = 21'(days_before(s3_m)) + 21'(s3_day) + 21'(jddc_pkg::JD_OFFSET);

  logic        s4_valid, s4_err;
  logic [3:0]  s4_mon;
  logic [4:0]  s4_day;
  logic [13:0] s4_yr;
  logic [21:0] s4_t1;
  logic [15:0] s4_t2;
  logic [20:0] s4_t3;

  // stage 5: final sum
  logic [22:0] jdn_c;
  assign jdn_c = 23'(s4_t1) + 23'(s4_t2) + 23'(s4_t3);

  jddc_pkg::beat_t s5_beat;
  jddc_pkg::beat_t align_q [ALIGN];

  always_ff @(posedge clk) begin
    s1_err <= err_c;
    s1_m   <= m_c;
    s1_y   <= y_c;
    s1_mon <= req.month_in;
    s1_day <= req.day_in;
    s1_yr  <= req.year_in;

    s2_err <= s1_err;
    s2_m   <= s1_m;
    s2_y   <= s1_y;
    s2_mon <= s1_mon;
    s2_day <= s1_day;
    s2_yr  <= s1_yr;
    s2_c   <= prod2[32:26];

    s3_err <= s2_err;
    s3_m   <= s2_m;
    s3_mon <= s2_mon;
    s3_day <= s2_day;
    s3_yr  <= s2_yr;
    s3_c   <= s2_c;
    s3_ya  <= ya_c[6:0];

    s4_err <= s3_err;
    s4_mon <= s3_mon;
    s4_day <= s3_day;
    s4_yr  <= s3_yr;
    s4_t1  <= t1_full[23:2];
    s4_t2  <= t2_full[17:2];
    s4_t3  <= t3_c;

    s5_beat.data.range_error    <= s4_err;
    s5_beat.data.day_number_out <= s4_err ? '0 : jdn_c;
    s5_beat.data.month_out      <= s4_err ? '0 : s4_mon;
    s5_beat.data.day_out        <= s4_err ? '0 : s4_day;
    s5_beat.data.year_out       <= s4_err ? '0 : s4_yr;

    align_q[0].data <= s5_beat.data;
    for (int i = 1; i < ALIGN; i++) begin
      align_q[i].data <= align_q[i-1].data;
    end

    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      s4_valid      <= 1'b0;
      s5_beat.valid <= 1'b0;
      for (int i = 0; i < ALIGN; i++) begin
        align_q[i].valid <= 1'b0;
      end
    end else begin
      s1_valid      <= in_valid;
      s2_valid      <= s1_valid;
      s3_valid      <= s2_valid;
      s4_valid      <= s3_valid;
      s5_beat.valid <= s4_valid;
      align_q[0].valid <= s5_beat.valid;
      for (int i = 1; i < ALIGN; i++) begin
        align_q[i].valid <= align_q[i-1].valid;
      end
    end
  end

  assign beat = align_q[ALIGN-1];

endmodule

### rtl/core/jddc_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddc_decode
// Julian day number to calendar date, eight register stages. Division by
// 146097, 1461 and 153 is a reciprocal estimate followed by one correcting subtract.
// ----------------------------------------------------------------------------
module jddc_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  jddc_pkg::req_t  req,
  output jddc_pkg::beat_t beat
);

  // floor reciprocals except RECIP_5, quotient estimate is exact or one low
  localparam logic [14:0] RECIP_400Y = 15'd29398;   // 2^32 / 146097
  localparam logic [16:0] RECIP_4Y   = 17'd91867;   // 2^27 / 1461
  localparam logic [8:0]  RECIP_5MON = 9'd428;      // 2^16 / 153
  localparam logic [7:0]  RECIP_5    = 8'd205;      // exact below 1024 after >>10

  // stage 1: range check and 4*(n - offset) - 1
  logic        err_c;
  logic [22:0] j_c;
  logic [23:0] a_c;
  assign err_c = (req.day_number_in < jddc_pkg::JD_MIN)
              || (req.day_number_in > jddc_pkg::JD_MAX);
  assign j_c   = req.day_number_in - jddc_pkg::JD_OFFSET;
  assign a_c   = {j_c[21:0], 2'b00} - 24'd1;

  logic        s1_valid, s1_err;
  logic [22:0] s1_n;
  logic [23:0] s1_a;

  // stage 2: century estimate
  logic [38:0] prod2;
  assign prod2 = 39'(s1_a) * 39'(RECIP_400Y);

  logic        s2_valid, s2_err;
  logic [22:0] s2_n;
  logic [23:0] s2_a;
  logic [6:0]  s2_qa;

  // stage 3: century correction
  logic [23:0] r3_raw;
  logic        r3_ge;
  assign r3_raw = s2_a - 24'(24'(s2_qa) * 24'(jddc_pkg::DAYS_400Y));
  assign r3_ge  = r3_raw >= 24'(jddc_pkg::DAYS_400Y);

  logic        s3_valid, s3_err;
  logic [22:0] s3_n;
  logic [6:0]  s3_cent;
  logic [17:0] s3_r;

  // stage 4: year estimate on 4*(r/4) + 3
  logic [17:0] b_c;
  logic [34:0] prod4;
  assign b_c   = {s3_r[17:2], 2'b11};
  assign prod4 = 35'(b_c) * 35'(RECIP_4Y);

  logic        s4_valid, s4_err;
  logic [22:0] s4_n;
  logic [6:0]  s4_cent, s4_qb;
  logic [17:0] s4_b;

  // stage 5: year correction
  logic [17:0] r5_raw;
  logic        r5_ge;
  assign r5_raw = s4_b - 18'(18'(s4_qb) * 18'(jddc_pkg::DAYS_4Y));
  assign r5_ge  = r5_raw >= 18'(jddc_pkg::DAYS_4Y);

  logic        s5_valid, s5_err;
  logic [22:0] s5_n;
  logic [6:0]  s5_cent, s5_yy;
  logic [10:0] s5_d;

  // stage 6: day of year to month estimate
  logic [11:0] d6_sum;
  logic [8:0]  d6;
  logic [10:0] e6;
  logic [19:0] prod6;
  assign d6_sum = 12'(s5_d) + 12'd4;
  assign d6     = d6_sum[10:2];
  assign e6     = 11'(11'(d6) * 11'd5) - 11'd3;
  assign prod6  = 20'(e6) * 20'(RECIP_5MON);

  logic        s6_valid, s6_err;
  logic [22:0] s6_n;
  logic [6:0]  s6_cent, s6_yy;
  logic [10:0] s6_e;
  logic [3:0]  s6_qm;

  // stage 7: month correction
  logic [10:0] r7_raw;
  logic        r7_ge;
  assign r7_raw = s6_e - 11'(11'(s6_qm) * 11'(jddc_pkg::DAYS_5MON));
  assign r7_ge  = r7_raw >= 11'(jddc_pkg::DAYS_5MON);

  logic        s7_valid, s7_err;
  logic [22:0] s7_n;
  logic [6:0]  s7_cent, s7_yy;
  logic [3:0]  s7_m;
  logic [7:0]  s7_dm;

  // stage 8: day, calendar month and year
  logic [15:0] prod8;
  logic [4:0]  day_c;
  logic [13:0] year_base;
  logic [3:0]  month_c;
  logic [13:0] year_c;
  assign prod8     = 16'(s7_dm) * 16'(RECIP_5);
  assign day_c     = 5'(prod8[15:10]) + 5'd1;
  assign year_base = 14'(14'(s7_cent) * 14'd100) + 14'(s7_yy);
  assign month_c   = (s7_m < 4'd10) ? s7_m + 4'd3 : s7_m - 4'd9;
  assign year_c    = (s7_m < 4'd10) ? year_base : year_base + 14'd1;

  jddc_pkg::beat_t s8_beat;

  always_ff @(posedge clk) begin
    s1_err <= err_c;
    s1_n   <= req.day_number_in;
    s1_a   <= a_c;

    s2_err <= s1_err;
    s2_n   <= s1_n;
    s2_a   <= s1_a;
    s2_qa  <= prod2[38:32];

    s3_err  <= s2_err;
    s3_n    <= s2_n;
    s3_cent <= r3_ge ? s2_qa + 7'd1 : s2_qa;
    s3_r    <= r3_ge ? 18'(r3_raw - 24'(jddc_pkg::DAYS_400Y)) : r3_raw[17:0];

    s4_err  <= s3_err;
    s4_n    <= s3_n;
    s4_cent <= s3_cent;
    s4_b    <= b_c;
    s4_qb   <= prod4[33:27];

    s5_err  <= s4_err;
    s5_n    <= s4_n;
    s5_cent <= s4_cent;
    s5_yy   <= r5_ge ? s4_qb + 7'd1 : s4_qb;
    s5_d    <= r5_ge ? 11'(r5_raw - 18'(jddc_pkg::DAYS_4Y)) : r5_raw[10:0];

    s6_err  <= s5_err;
    s6_n    <= s5_n;
    s6_cent <= s5_cent;
    s6_yy   <= s5_yy;
    s6_e    <= e6;
    s6_qm   <= prod6[19:16];

    s7_err  <= s6_err;
    s7_n    <= s6_n;
    s7_cent <= s6_cent;
    s7_yy   <= s6_yy;
    s7_m    <= r7_ge ? s6_qm + 4'd1 : s6_qm;
    s7_dm   <= r7_ge ? 8'(r7_raw - 11'(jddc_pkg::DAYS_5MON)) : r7_raw[7:0];

    s8_beat.data.range_error    <= s7_err;
    s8_beat.data.day_number_out <= s7_err ? '0 : s7_n;
    s8_beat.data.month_out      <= s7_err ? '0 : month_c;
    s8_beat.data.day_out        <= s7_err ? '0 : day_c;
    s8_beat.data.year_out       <= s7_err ? '0 : year_c;

    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      s4_valid      <= 1'b0;
      s5_valid      <= 1'b0;
      s6_valid      <= 1'b0;
      s7_valid      <= 1'b0;
      s8_beat.valid <= 1'b0;
    end else begin
      s1_valid      <= in_valid;
      s2_valid      <= s1_valid;
      s3_valid      <= s2_valid;
      s4_valid      <= s3_valid;
      s5_valid      <= s4_valid;
      s6_valid      <= s5_valid;
      s7_valid      <= s6_valid;
      s8_beat.valid <= s7_valid;
    end
  end

  assign beat = s8_beat;

endmodule

### rtl/core/julian_day_date_converter_unit.sv
`timescale 1ns / 1ps
// result: a request taken at a clock edge passes the eight path stages and
//   the output register, then shows its result on the result ports for one
//   cycle, marked by done
// throughput: one request per cycle in either direction; busy stays low
// reset: clears all valid bits, no result appears until new requests enter
// ----------------------------------------------------------------------------
// julian_day_date_converter_unit
// Gregorian date to Julian day number and back, fully pipelined.
// ----------------------------------------------------------------------------
module julian_day_date_converter_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  jddc_pkg::req_t request,
  output logic           done,
  output jddc_pkg::rsp_t result
);

  localparam int unsigned LATENCY = jddc_pkg::PATH_STAGES + 1;

  logic            take;
  jddc_pkg::beat_t enc_beat;
  jddc_pkg::beat_t dec_beat;

  assign busy = 1'b0;
  assign take = start && !busy;

  jddc_encode u_encode (
    .clk      (clk),
    .rst      (rst),
    .in_valid (take && (request.req_type == jddc_pkg::REQ_DATE_TO_JDN)),
    .req      (request),
    .beat     (enc_beat)
  );

  jddc_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .in_valid (take && (request.req_type == jddc_pkg::REQ_JDN_TO_DATE)),
    .req      (request),
    .beat     (dec_beat)
  );

  // both paths have the same depth, so at most one of them fires per cycle
  always_ff @(posedge clk) begin
    result <= enc_beat.valid ? enc_beat.data : dec_beat.data;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= enc_beat.valid || dec_beat.valid;
    end
  end

  a_paths_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({enc_beat.valid, dec_beat.valid}))
    else $error("both conversion paths produced a result in one cycle");

  a_request_to_result: assert property (@(posedge clk) disable iff (rst)
    take |-> ##LATENCY done)
    else $error("request did not produce a result at the fixed latency");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, LATENCY))
    else $error("result appeared without a matching request");

  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    (done && result.range_error) |-> (result.day_number_out == '0)
      && (result.month_out == '0) && (result.day_out == '0)
      && (result.year_out == '0))
    else $error("range error result carries non-zero fields");

endmodule
